@@ rtl/core/rqcp_pkg.sv @@
// Shared types and codes for the PCM requantize, clip and pack block.
// No dependencies.
package rqcp_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CODE_W   = 24;
    localparam int PEAK_W   = 29;
    localparam int CFG_W    = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_FORMAT = 1'd1;

    localparam logic       QUANT_ROUND  = 1'b0;
    localparam logic [2:0] FMT_RESET    = 3'd1;
    localparam logic [7:0] U8_OFFSET    = 8'h80;

    typedef enum logic [2:0] {
        FMT_U8    = 3'd0,
        FMT_S16LE = 3'd1,
        FMT_S16BE = 3'd2,
        FMT_S24LE = 3'd3,
        FMT_S24BE = 3'd4,
        FMT_S32LE = 3'd5,
        FMT_S32BE = 3'd6
    } t_fmt;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W24 = 2'd2
    } t_width;

    typedef struct packed {
        logic [PEAK_W-1:0]   peak_level;
        logic [SAMPLE_W-1:0] clip_count;
        logic [SAMPLE_W-1:0] peak_overshoot;
    } t_stats;

    function automatic t_width fmt_width(input logic [2:0] fmt);
        t_width w;
        case (t_fmt'(fmt))
            FMT_U8:                                  w = W8;
            FMT_S16LE, FMT_S16BE:                    w = W16;
            FMT_S24LE, FMT_S24BE, FMT_S32LE, FMT_S32BE: w = W24;
            default:                                 w = W16;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/rqcp_pack.sv @@
// Byte packer: turns a 24-bit sample code into output bytes in write order.
// Depends on rqcp_pkg.
module rqcp_pack (
    input  logic [rqcp_pkg::CODE_W-1:0]   i_code,
    input  logic [2:0]                    i_fmt,
    output logic [rqcp_pkg::SAMPLE_W-1:0] o_packed,
    output logic [2:0]                    o_count
);

    logic [7:0] b0, b1, b2;

    assign b0 = i_code[7:0];
    assign b1 = i_code[15:8];
    assign b2 = i_code[23:16];

    always_comb begin
        case (rqcp_pkg::t_fmt'(i_fmt))
            rqcp_pkg::FMT_U8: begin
                o_packed = {24'd0, b0 ^ rqcp_pkg::U8_OFFSET};
                o_count  = 3'd1;
            end
            rqcp_pkg::FMT_S16LE: begin
                o_packed = {16'd0, b1, b0};
                o_count  = 3'd2;
            end
            rqcp_pkg::FMT_S16BE: begin
                o_packed = {16'd0, b0, b1};
                o_count  = 3'd2;
            end
            rqcp_pkg::FMT_S24LE: begin
                o_packed = {8'd0, b2, b1, b0};
                o_count  = 3'd3;
            end
            rqcp_pkg::FMT_S24BE: begin
                o_packed = {8'd0, b0, b1, b2};
                o_count  = 3'd3;
            end
            rqcp_pkg::FMT_S32LE: begin
                o_packed = {b2, b1, b0, 8'd0};
                o_count  = 3'd4;
            end
            rqcp_pkg::FMT_S32BE: begin
                o_packed = {8'd0, b0, b1, b2};
                o_count  = 3'd4;
            end
            default: begin
                o_packed = {16'd0, b1, b0};
                o_count  = 3'd2;
            end
        endcase
    end

endmodule

@@ rtl/core/rqcp_quant.sv @@
// Requantizer with clipping, level statistics and per-channel error feedback.
// Holds the statistics and error registers. Depends on rqcp_pkg.
module rqcp_quant #(
    parameter int FRAC_BITS = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_quant_mode,
    input  rqcp_pkg::t_width              i_width,
    input  logic [rqcp_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_channel,
    output logic [rqcp_pkg::CODE_W-1:0]   o_code,
    output rqcp_pkg::t_stats              o_stats
);

    localparam int PW = FRAC_BITS + 1;
    localparam int SH8  = FRAC_BITS + 1 - 8;
    localparam int SH16 = FRAC_BITS + 1 - 16;
    localparam int SH24 = FRAC_BITS + 1 - 24;
    localparam logic [31:0] RND8  = 32'd1 << (FRAC_BITS - 8);
    localparam logic [31:0] RND16 = 32'd1 << (FRAC_BITS - 16);
    localparam logic [31:0] RND24 = 32'd1 << (FRAC_BITS - 24);
    localparam logic signed [32:0] ONE_S = signed'(33'd1 << FRAC_BITS);

    logic [PW-1:0] r_peak, n_peak;
    logic [31:0]   r_clip, n_clip;
    logic [31:0]   r_over, n_over;
    logic [31:0]   r_err [2];

    logic [31:0] err, addend, v, mag, lim, mask, qu, err_next, over, peak_ext;
    logic signed [32:0] v_s, peak_s, q_s, over_s;
    logic signed [31:0] code_full;
    logic ge_peak, lt_neg, hi, lo, clip, may_record;

    assign err = r_err[i_channel];
    assign mag = err[31] ? (32'd0 - err) : err;

    always_comb begin
        case (i_width)
            rqcp_pkg::W8: begin
                addend = RND8;
                lim    = 32'd1 << 7;
                mask   = (32'd1 << SH8) - 32'd1;
            end
            rqcp_pkg::W24: begin
                addend = RND24;
                lim    = 32'd1 << 23;
                mask   = (32'd1 << SH24) - 32'd1;
            end
            default: begin
                addend = RND16;
                lim    = 32'd1 << 15;
                mask   = (32'd1 << SH16) - 32'd1;
            end
        endcase
    end

    assign v          = i_sample + ((i_quant_mode == rqcp_pkg::QUANT_ROUND) ? addend : err);
    assign may_record = (i_quant_mode == rqcp_pkg::QUANT_ROUND) || (mag < lim);

    assign v_s    = signed'({v[31], v});
    assign peak_s = signed'(33'(r_peak));
    assign ge_peak = v_s >= peak_s;
    assign lt_neg  = v_s < -peak_s;
    assign hi      = v_s >= ONE_S;
    assign lo      = v_s < -ONE_S;

    always_comb begin
        q_s    = v_s;
        clip   = 1'b0;
        n_peak = r_peak;
        if (ge_peak) begin
            if (hi) begin
                clip = 1'b1;
                q_s  = ONE_S - 33'sd1;
            end
            n_peak = q_s[PW-1:0];
        end else if (lt_neg) begin
            if (lo) begin
                clip = 1'b1;
                q_s  = -ONE_S;
            end
            n_peak = PW'(-q_s);
        end
    end

    assign over_s = hi ? (v_s - (ONE_S - 33'sd1)) : (-ONE_S - v_s);
    assign over   = over_s[31:0];
    assign n_clip = r_clip + 32'(clip);
    assign n_over = (clip && may_record && (over > r_over)) ? over : r_over;

    // low bits cleared; in round mode the shift drops them anyway
    assign qu       = q_s[31:0] & ~mask;
    assign err_next = v - qu;

    always_comb begin
        case (i_width)
            rqcp_pkg::W8:  code_full = signed'(qu) >>> SH8;
            rqcp_pkg::W24: code_full = signed'(qu) >>> SH24;
            default:       code_full = signed'(qu) >>> SH16;
        endcase
    end

    assign o_code   = code_full[rqcp_pkg::CODE_W-1:0];
    assign peak_ext = 32'(n_peak);

    assign o_stats.peak_level     = peak_ext[rqcp_pkg::PEAK_W-1:0];
    assign o_stats.clip_count     = n_clip;
    assign o_stats.peak_overshoot = n_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak   <= '0;
            r_clip   <= '0;
            r_over   <= '0;
            r_err[0] <= '0;
            r_err[1] <= '0;
        end else if (i_en) begin
            r_peak <= n_peak;
            r_clip <= n_clip;
            r_over <= n_over;
            if (i_quant_mode != rqcp_pkg::QUANT_ROUND) begin
                r_err[i_channel] <= err_next;
            end
        end
    end

endmodule

@@ rtl/core/pcm_requantize_clip_pack_top.sv @@
// PCM requantize, clip and pack: top level with input and result registers.
// Depends on rqcp_pkg, rqcp_quant and rqcp_pack.
//
// Takes one sample request per clock cycle while not stalled and delivers one
// packed result per request, passing through the input register and then the
// result register. The rate is one sample per cycle while the output side is
// ready; each sample reads and writes the peak, clip, overshoot and error
// registers as it moves on. While a finished result waits in the result
// register, the input register can take one more request; after that the
// input stalls until the result is taken. Configuration writes take effect at
// once and are meant for idle periods; register 0 selects rounding or
// error-feedback dither, register 1 the output byte format.
module pcm_requantize_clip_pack_top #(
    parameter int FRAC_BITS = 28
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rqcp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rqcp_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [31:0]               i_sample_value,
    input  logic                             i_channel,
    input  logic                             i_block_end,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [31:0]                      o_packed_bytes,
    output logic [2:0]                       o_byte_count,
    output logic                             o_block_end_out,
    output logic [28:0]                      o_peak_level_out,
    output logic [31:0]                      o_clip_count_out,
    output logic [31:0]                      o_peak_overshoot_out
);

    logic       r_quant_mode;
    logic [2:0] r_out_format;

    logic        r_in_valid;
    logic [31:0] r_sample;
    logic        r_channel;
    logic        r_block_end;

    logic             r_out_valid;
    logic [31:0]      r_packed;
    logic [2:0]       r_count;
    logic             r_block_end_out;
    rqcp_pkg::t_stats r_stats;

    logic                           advance;
    logic [rqcp_pkg::CODE_W-1:0]    code;
    logic [31:0]                    packed_bytes;
    logic [2:0]                     byte_count;
    rqcp_pkg::t_stats               stats;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_mode <= rqcp_pkg::QUANT_ROUND;
            r_out_format <= rqcp_pkg::FMT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rqcp_pkg::CFG_QUANT_MODE: r_quant_mode <= i_cfg_wdata[0];
                rqcp_pkg::CFG_OUT_FORMAT: r_out_format <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample    <= i_sample_value;
            r_channel   <= i_channel;
            r_block_end <= i_block_end;
        end
    end

    rqcp_quant #(
        .FRAC_BITS (FRAC_BITS)
    ) u_quant (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_quant_mode (r_quant_mode),
        .i_width      (rqcp_pkg::fmt_width(r_out_format)),
        .i_sample     (r_sample),
        .i_channel    (r_channel),
        .o_code       (code),
        .o_stats      (stats)
    );

    rqcp_pack u_pack (
        .i_code   (code),
        .i_fmt    (r_out_format),
        .o_packed (packed_bytes),
        .o_count  (byte_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_packed        <= packed_bytes;
            r_count         <= byte_count;
            r_block_end_out <= r_block_end;
            r_stats         <= stats;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_packed_bytes       = r_packed;
    assign o_byte_count         = r_count;
    assign o_block_end_out      = r_block_end_out;
    assign o_peak_level_out     = r_stats.peak_level;
    assign o_clip_count_out     = r_stats.clip_count;
    assign o_peak_overshoot_out = r_stats.peak_overshoot;

endmodule

@@ rtl/core/rqcp_checker.sv @@
// Port-level checks for the PCM requantize, clip and pack top level.
// Bound to pcm_requantize_clip_pack_top; no package dependencies.
module rqcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_packed_bytes,
    input logic [2:0]  o_byte_count,
    input logic [31:0] o_clip_count_out,
    input logic [31:0] o_peak_overshoot_out
);

    logic        r_seen;
    logic [31:0] r_last_clip;
    logic [31:0] r_last_over;
    logic        out_take;

    assign out_take = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_clip <= '0;
            r_last_over <= '0;
        end else if (out_take) begin
            r_seen      <= 1'b1;
            r_last_clip <= o_clip_count_out;
            r_last_over <= o_peak_overshoot_out;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_packed_bytes)))
        else $error("result request dropped or changed while stalled");

    a_clip_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && r_seen) |->
            (o_clip_count_out == r_last_clip || o_clip_count_out == r_last_clip + 32'd1))
        else $error("clip count moved by more than one sample");

    a_over_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && r_seen) |-> (o_peak_overshoot_out >= r_last_over))
        else $error("peak overshoot decreased");

    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_byte_count == 3'd1 && o_packed_bytes[31:8] == 24'd0)
            || (o_byte_count == 3'd2 && o_packed_bytes[31:16] == 16'd0)
            || (o_byte_count == 3'd3 && o_packed_bytes[31:24] == 8'd0)
            || (o_byte_count == 3'd4 && o_packed_bytes[7:0] == 8'd0)
            || (o_byte_count == 3'd4 && o_packed_bytes[31:24] == 8'd0)))
        else $error("byte count and packed bytes disagree");

endmodule

bind pcm_requantize_clip_pack_top rqcp_checker u_rqcp_checker (.*);

@@ verif/pcm_requantize_clip_pack_top_tb.sv @@
// Self-checking testbench for pcm_requantize_clip_pack_top: directed and random samples
// across all quantizer modes and output formats, with a predictor-based scoreboard.
// Depends on rqcp_pkg and the pcm_requantize_clip_pack_top RTL.
module pcm_requantize_clip_pack_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC        = 28;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 115;

    typedef struct {
        logic [31:0] bytes;
        logic [2:0]  count;
        logic        blk_end;
        logic [28:0] peak;
        logic [31:0] clips;
        logic [31:0] overshoot;
    } t_pcm_result;

    class t_requant_scoreboard;
        bit          dither;
        logic [2:0]  out_fmt;
        logic [31:0] peak;
        logic [31:0] clips;
        logic [31:0] overshoot;
        logic [31:0] err [2];
        t_pcm_result expected_q [$];
        int          failures;

        function new();
            dither    = rqcp_pkg::QUANT_ROUND;
            out_fmt   = rqcp_pkg::FMT_RESET;
            peak      = '0;
            clips     = '0;
            overshoot = '0;
            err[0]    = '0;
            err[1]    = '0;
            failures  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint clip_track(longint v, bit may_record);
            longint one;
            longint q;
            longint over;
            one = longint'(1) << FRAC;
            q = v;
            if (v >= longint'(peak)) begin
                if (v >= one) begin
                    over = v - (one - 1);
                    clips = clips + 32'd1;
                    if (may_record && over > longint'(overshoot))
                        overshoot = over[31:0];
                    q = one - 1;
                end
                peak = q[31:0];
            end else if (v < -longint'(peak)) begin
                if (v < -one) begin
                    over = -one - v;
                    clips = clips + 32'd1;
                    if (may_record && over > longint'(overshoot))
                        overshoot = over[31:0];
                    q = -one;
                end
                peak = 32'd0 - q[31:0];
            end
            return q;
        endfunction

        function t_pcm_result predict_packed(logic [31:0] x, bit ch, bit be);
            logic [2:0]  f;
            int          bits;
            int          s;
            logic [31:0] v;
            logic [31:0] e;
            logic [31:0] mag;
            logic [31:0] limit;
            logic [31:0] qu;
            logic [31:0] code;
            longint      q;
            logic [7:0]  b0;
            logic [7:0]  b1;
            logic [7:0]  b2;
            t_pcm_result r;
            f = (out_fmt == 3'd7) ? rqcp_pkg::FMT_S16LE : out_fmt;
            bits = (f == rqcp_pkg::FMT_U8) ? 8 : ((f <= rqcp_pkg::FMT_S16BE) ? 16 : 24);
            s = FRAC + 1 - bits;
            if (!dither) begin
                v = x + (32'd1 << (FRAC - bits));
                q = clip_track(longint'($signed(v)), 1'b1);
                qu = q[31:0];
            end else begin
                e = err[ch];
                v = x + e;
                mag = e[31] ? (32'd0 - e) : e;
                limit = (32'd1 << FRAC) >> s;
                q = clip_track(longint'($signed(v)), mag < limit);
                qu = q[31:0] & ~((32'd1 << s) - 32'd1);
                err[ch] = v - qu;
            end
            code = $unsigned($signed(qu) >>> s);
            b0 = code[7:0];
            b1 = code[15:8];
            b2 = code[23:16];
            case (f)
                rqcp_pkg::FMT_U8: begin
                    r.bytes = {24'd0, b0 + rqcp_pkg::U8_OFFSET};
                    r.count = 3'd1;
                end
                rqcp_pkg::FMT_S16LE: begin
                    r.bytes = {16'd0, b1, b0};
                    r.count = 3'd2;
                end
                rqcp_pkg::FMT_S16BE: begin
                    r.bytes = {16'd0, b0, b1};
                    r.count = 3'd2;
                end
                rqcp_pkg::FMT_S24LE: begin
                    r.bytes = {8'd0, b2, b1, b0};
                    r.count = 3'd3;
                end
                rqcp_pkg::FMT_S24BE: begin
                    r.bytes = {8'd0, b0, b1, b2};
                    r.count = 3'd3;
                end
                rqcp_pkg::FMT_S32LE: begin
                    r.bytes = {b2, b1, b0, 8'd0};
                    r.count = 3'd4;
                end
                default: begin
                    r.bytes = {8'd0, b0, b1, b2};
                    r.count = 3'd4;
                end
            endcase
            r.blk_end   = be;
            r.peak      = peak[28:0];
            r.clips     = clips;
            r.overshoot = overshoot;
            return r;
        endfunction

        function void note_sample(logic [31:0] x, bit ch, bit be);
            expected_q.push_back(predict_packed(x, ch, be));
        endfunction

        function void check_packed(logic [31:0] bytes, logic [2:0] count, logic be,
                                   logic [28:0] pk, logic [31:0] cl, logic [31:0] ov);
            t_pcm_result exp_r;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: bytes %h count %0d", bytes, count);
                return;
            end
            exp_r = expected_q.pop_front();
            if (bytes !== exp_r.bytes || count !== exp_r.count || be !== exp_r.blk_end ||
                pk !== exp_r.peak || cl !== exp_r.clips || ov !== exp_r.overshoot) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch exp: bytes %h cnt %0d end %0d peak %h clips %h over %h",
                             exp_r.bytes, exp_r.count, exp_r.blk_end, exp_r.peak,
                             exp_r.clips, exp_r.overshoot);
                    $display("         got: bytes %h cnt %0d end %0d peak %h clips %h over %h",
                             bytes, count, be, pk, cl, ov);
                end
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rqcp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rqcp_pkg::CFG_W-1:0]      i_cfg_wdata;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic signed [31:0]              i_sample_value;
    logic                            i_channel;
    logic                            i_block_end;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [31:0]                     o_packed_bytes;
    logic [2:0]                      o_byte_count;
    logic                            o_block_end_out;
    logic [28:0]                     o_peak_level_out;
    logic [31:0]                     o_clip_count_out;
    logic [31:0]                     o_peak_overshoot_out;

    t_requant_scoreboard sb;
    bit tx_idle_on;
    bit rx_idle_on;
    int hold_off;
    int cycle_count;

    pcm_requantize_clip_pack_top #(
        .FRAC_BITS(FRAC)
    ) u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_sample_value       (i_sample_value),
        .i_channel            (i_channel),
        .i_block_end          (i_block_end),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_packed_bytes       (o_packed_bytes),
        .o_byte_count         (o_byte_count),
        .o_block_end_out      (o_block_end_out),
        .o_peak_level_out     (o_peak_level_out),
        .o_clip_count_out     (o_clip_count_out),
        .o_peak_overshoot_out (o_peak_overshoot_out)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pcm_requantize_clip_pack_top_tb NOT OK");
            $finish;
        end
    end

    // results are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_packed(o_packed_bytes, o_byte_count, o_block_end_out,
                                o_peak_level_out, o_clip_count_out, o_peak_overshoot_out);
            if (i_in_valid && o_in_ready)
                sb.note_sample(i_sample_value, i_channel, i_block_end);
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_out_ready <= 1'b0;
            hold_off--;
        end else if (rx_idle_on && $urandom_range(0, 99) < 33) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [31:0] x, input bit ch, input bit be);
        while (tx_idle_on && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= x;
        i_channel      <= ch;
        i_block_end    <= be;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_regs(input bit dither, input logic [2:0] fmt);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rqcp_pkg::CFG_QUANT_MODE;
        i_cfg_wdata <= {2'b00, dither};
        @(negedge i_clk);
        i_cfg_index <= rqcp_pkg::CFG_OUT_FORMAT;
        i_cfg_wdata <= fmt;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.dither  = dither;
        sb.out_fmt = fmt;
    endtask

    function automatic logic [31:0] random_sample();
        logic [31:0] x;
        int          sh;
        case ($urandom_range(0, 9))
            0, 1, 2: x = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
            3, 4: begin
                x = 32'h1000_0000 + $urandom_range(0, 4095) - 32'd2048;
                if ($urandom_range(0, 1))
                    x = 32'd0 - x;
            end
            5, 6: x = $urandom;
            7: x = $urandom_range(0, 2047) - 32'd1024;
            8: begin
                // just below or at a rounding step
                sh = 4 + 8 * int'($urandom_range(0, 2));
                x = ($urandom & 32'h0FFF_FFFF) & ~((32'd1 << (sh + 1)) - 32'd1);
                x = x + (32'd1 << sh) - $urandom_range(0, 1);
                if ($urandom_range(0, 1))
                    x = 32'd0 - x;
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: x = 32'h7FFF_FFFF;
                    1: x = 32'h8000_0000;
                    2: x = 32'h1000_0000;
                    3: x = 32'h0FFF_FFFF;
                    4: x = 32'hF000_0000;
                    default: x = 32'hEFFF_FFFF;
                endcase
            end
        endcase
        return x;
    endfunction

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = rqcp_pkg::CFG_QUANT_MODE;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_sample_value = '0;
        i_channel      = 1'b0;
        i_block_end    = 1'b0;
        i_out_ready    = 1'b0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        hold_off       = 0;
        cycle_count    = 0;
        sb = new();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: rounding, s16le
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_sample(32'h0000_0001, 1'b1, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h0000_0FFF, 1'b0, 1'b0);
        send_sample(32'h0000_1000, 1'b1, 1'b0);
        send_sample(32'h0FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h1000_0000, 1'b0, 1'b0);
        send_sample(32'hF000_0000, 1'b1, 1'b0);
        send_sample(32'hEFFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b1, 1'b1);
        drain();

        // dither into u8, with wrapping sums and a gated overshoot
        program_regs(1'b1, rqcp_pkg::FMT_U8);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b1, 1'b0);
        send_sample(32'h0012_3456, 1'b1, 1'b0);
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_sample(32'hF000_0000, 1'b1, 1'b0);
        send_sample(32'h0010_0000, 1'b0, 1'b1);
        drain();

        // unused format code falls back to s16le
        program_regs(1'b0, 3'd7);
        send_sample(32'h0012_3456, 1'b0, 1'b0);
        send_sample(32'hFFED_CBA9, 1'b1, 1'b1);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            tx_idle_on = (ph != 5);
            rx_idle_on = (ph != 5);
            program_regs(1'(ph / 8), 3'(ph % 8));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 10 && n == 40) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    hold_off = 48;
                    @(negedge i_clk);
                end
                send_sample(random_sample(), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 15) == 0);
            end
            drain();
        end

        repeat (8) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("pcm_requantize_clip_pack_top_tb OK");
        end else begin
            $display("pcm_requantize_clip_pack_top_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rqcp_pkg.sv
rtl/core/rqcp_pack.sv
rtl/core/rqcp_quant.sv
rtl/core/pcm_requantize_clip_pack_top.sv
rtl/core/rqcp_checker.sv
verif/pcm_requantize_clip_pack_top_tb.sv
